// ===== design/mrrb_pkg.sv =====
package mrrb_pkg;

  localparam int DEPTH         = 4096;
  localparam int MAX_CONSUMERS = 64;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CIDX_W = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int BYTE_W = 8;
  localparam int FILL_W = 12;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  typedef struct packed {
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [FILL_W-1:0] fill;
  } result_t;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

endpackage

// ===== design/mrrb_store.sv =====
module mrrb_store (
  input  logic                      clk,
  input  mrrb_pkg::mem_req_t        req,
  output logic [mrrb_pkg::BYTE_W-1:0] rd_data
);
  import mrrb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== design/mrrb_ctrl.sv =====
module mrrb_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_req,
  input  logic [mrrb_pkg::BYTE_W-1:0] in_byte,
  input  logic [mrrb_pkg::IDX_W-1:0]  in_idx,
  input  logic [mrrb_pkg::CNT_W-1:0]  consumers_in_use,
  output mrrb_pkg::mem_req_t          mem_req,
  output mrrb_pkg::result_t           result
);
  import mrrb_pkg::*;

  localparam int DW = (PTR_W + 1 > FILL_W) ? PTR_W + 1 : FILL_W;

  logic [PTR_W-1:0] write_position;
  logic [PTR_W-1:0] read_positions [MAX_CONSUMERS];

  logic [CNT_W-1:0]  n_active;
  logic [PTR_W-1:0]  wp_adv;
  logic              full;
  logic              idx_ok;
  logic [CIDX_W-1:0] sel;
  logic [PTR_W-1:0]  rp_cur;
  logic [PTR_W-1:0]  rp_adv;
  logic [DW-1:0]     diff;
  logic              do_write;
  logic              do_read;

  always_comb begin
    n_active = (consumers_in_use > CNT_W'(MAX_CONSUMERS)) ? CNT_W'(MAX_CONSUMERS)
                                                          : consumers_in_use;
    wp_adv = advance(write_position);
    // parallel compare of the next write slot against every active reader
    full = 1'b0;
    for (int k = 0; k < MAX_CONSUMERS; k++) begin
      if ((CNT_W'(k) < n_active) && (read_positions[k] == wp_adv)) begin
        full = 1'b1;
      end
    end

    idx_ok = CNT_W'(in_idx) < n_active;
    sel    = in_idx[CIDX_W-1:0];
    rp_cur = read_positions[sel];
    rp_adv = advance(rp_cur);

    if (write_position >= rp_adv) begin
      diff = DW'(write_position) - DW'(rp_adv);
    end else begin
      diff = DW'(write_position) + DW'(DEPTH) - DW'(rp_adv);
    end

    do_write = 1'b0;
    do_read  = 1'b0;
    result.status = ST_OK;
    result.fill   = '0;
    if (in_req == REQ_WRITE) begin
      if (full) begin
        result.status = ST_FULL;
      end else begin
        do_write = in_valid;
      end
    end else if (!idx_ok) begin
      result.status = ST_BADIDX;
    end else if (rp_cur == write_position) begin
      result.status = ST_EMPTY;
    end else begin
      do_read = in_valid;
      result.fill = (diff > DW'(4095)) ? FILL_W'(4095) : diff[FILL_W-1:0];
    end

    mem_req.wr_en   = do_write;
    mem_req.wr_addr = write_position;
    mem_req.wr_data = in_byte;
    mem_req.rd_en   = do_read;
    mem_req.rd_addr = rp_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      for (int k = 0; k < MAX_CONSUMERS; k++) begin
        read_positions[k] <= '0;
      end
    end else begin
      if (do_write) begin
        write_position <= wp_adv;
      end
      if (do_read) begin
        read_positions[sel] <= rp_adv;
      end
    end
  end

endmodule

// ===== design/multi_reader_ring_buffer.sv =====
// A request is captured in the request register, and its result in the result register.
// Throughput: one request per cycle; busy stays low, the read positions and the full
// check resolve combinationally between the request register and the result register.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset: write and read positions clear to zero, consumers_in_use returns to 1;
// the byte store is not cleared.
module multi_reader_ring_buffer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [mrrb_pkg::BYTE_W-1:0] write_byte,
  input  logic [mrrb_pkg::IDX_W-1:0]  consumer_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mrrb_pkg::CNT_W-1:0]  cfg_data,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [mrrb_pkg::BYTE_W-1:0] read_byte,
  output logic [mrrb_pkg::FILL_W-1:0] fill_level
);
  import mrrb_pkg::*;

  logic              consumers_cfg;
  logic [CNT_W-1:0]  consumers_in_use;

  logic              in_valid;
  logic              in_req;
  logic [BYTE_W-1:0] in_byte;
  logic [IDX_W-1:0]  in_idx;

  mem_req_t          mem_req;
  result_t           result;
  logic [BYTE_W-1:0] rd_data;

  logic              rd_ok;
  status_t           status_q;
  logic [FILL_W-1:0] fill_q;

  assign busy          = 1'b0;
  assign cfg_ready     = 1'b1;
  assign consumers_cfg = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      consumers_in_use <= CNT_W'(1);
    end else if (consumers_cfg) begin
      consumers_in_use <= cfg_data;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_req  <= req_type;
    in_byte <= write_byte;
    in_idx  <= consumer_index;
  end

  mrrb_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_req           (in_req),
    .in_byte          (in_byte),
    .in_idx           (in_idx),
    .consumers_in_use (consumers_in_use),
    .mem_req          (mem_req),
    .result           (result)
  );

  mrrb_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // result register, aligned with the store's registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    rd_ok    <= mem_req.rd_en;
    status_q <= result.status;
    fill_q   <= result.fill;
  end

  assign status     = status_q;
  assign fill_level = fill_q;
  assign read_byte  = rd_ok ? rd_data : '0;

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrrb_pkg::*;

  typedef struct packed {
    status_t           st;
    logic [BYTE_W-1:0] rb;
    logic [FILL_W-1:0] fl;
  } reply_t;

  // Mirror of the buffer: shared write position, per-consumer read positions, byte store.
  class ring_scoreboard;
    int unsigned       consumers;
    logic [PTR_W-1:0]  wr_pos;
    logic [PTR_W-1:0]  rd_pos [MAX_CONSUMERS];
    logic [BYTE_W-1:0] store [DEPTH];
    reply_t            replies_due [$];
    int unsigned       errors;
    int unsigned       n_req, n_wr_taken, n_full, n_rd_taken, n_empty, n_badidx;

    function new();
      consumers = 1;
      wr_pos = '0;
      foreach (rd_pos[k]) rd_pos[k] = '0;
      errors = 0;
      n_req = 0;
      n_wr_taken = 0;
      n_full = 0;
      n_rd_taken = 0;
      n_empty = 0;
      n_badidx = 0;
    endfunction

    function void set_consumers(logic [CNT_W-1:0] v);
      consumers = v;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    function void note_request(req_t rt, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] ci);
      int unsigned      n_act;
      int unsigned      fill;
      int               k;
      logic [PTR_W-1:0] nxt;
      logic [PTR_W-1:0] rp;
      bit               full;
      reply_t           r;
      n_act = (consumers > MAX_CONSUMERS) ? MAX_CONSUMERS : consumers;
      r.st = ST_OK;
      r.rb = '0;
      r.fl = '0;
      n_req++;
      if (rt == REQ_WRITE) begin
        nxt = (wr_pos == PTR_W'(DEPTH - 1)) ? '0 : wr_pos + 1'b1;
        full = 1'b0;
        for (k = 0; k < n_act; k++)
          if (rd_pos[k] == nxt) full = 1'b1;
        if (full) begin
          r.st = ST_FULL;
          n_full++;
        end else begin
          store[wr_pos] = b;
          wr_pos = nxt;
          n_wr_taken++;
        end
      end else if (ci >= n_act) begin
        r.st = ST_BADIDX;
        n_badidx++;
      end else begin
        rp = rd_pos[ci];
        if (rp == wr_pos) begin
          r.st = ST_EMPTY;
          n_empty++;
        end else begin
          r.rb = store[rp];
          rp = (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + 1'b1;
          rd_pos[ci] = rp;
          fill = (wr_pos >= rp) ? wr_pos - rp : wr_pos + DEPTH - rp;
          if (fill > 4095) fill = 4095;
          r.fl = FILL_W'(fill);
          n_rd_taken++;
        end
      end
      replies_due.push_back(r);
    endfunction

    function void report(string what, int unsigned exp_v, int unsigned act_v);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
      else if (errors == 41)
        $display("%0t: further mismatches not shown", $time);
    endfunction

    function void check_result(logic [1:0] st, logic [BYTE_W-1:0] rb, logic [FILL_W-1:0] fl);
      reply_t e;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status=%0d byte=%0d fill=%0d",
                 $time, st, rb, fl);
        return;
      end
      e = replies_due.pop_front();
      if (st !== e.st) report("status", e.st, st);
      if (rb !== e.rb) report("read_byte", e.rb, rb);
      if (fl !== e.fl) report("fill_level", e.fl, fl);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              req_type = 1'b0;
  logic [BYTE_W-1:0] write_byte = '0;
  logic [IDX_W-1:0]  consumer_index = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;
  logic              done;
  logic [1:0]        status;
  logic [BYTE_W-1:0] read_byte;
  logic [FILL_W-1:0] fill_level;

  ring_scoreboard sb = new();
  int unsigned    n_cfg = 0;

  multi_reader_ring_buffer dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .write_byte     (write_byte),
    .consumer_index (consumer_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .read_byte      (read_byte),
    .fill_level     (fill_level)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // results at an edge belong to older requests, so check before noting the new transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, read_byte, fill_level);
      if (cfg_valid && cfg_ready) sb.set_consumers(cfg_data);
      if (start && !busy) sb.note_request(req_t'(req_type), write_byte, consumer_index);
    end
  end

  task automatic send_req(input req_t rt, input logic [BYTE_W-1:0] b,
                          input logic [IDX_W-1:0] ci);
    start <= 1'b1;
    req_type <= rt;
    write_byte <= b;
    consumer_index <= ci;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_write(input logic [BYTE_W-1:0] b);
    send_req(REQ_WRITE, b, IDX_W'($urandom));
  endtask

  task automatic send_read(input logic [IDX_W-1:0] ci);
    send_req(REQ_READ, BYTE_W'($urandom), ci);
  endtask

  task automatic pause();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < 55) len = 0;
    else if (r < 90) len = $urandom_range(1, 3);
    else if (r < 97) len = $urandom_range(4, 10);
    else len = $urandom_range(11, 40);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (start) start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_consumers(input int unsigned v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= CNT_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // mostly readers in use, sometimes any index to hit the inactive case
  function automatic logic [IDX_W-1:0] pick_reader(input int unsigned n);
    int unsigned n_act;
    n_act = (n > MAX_CONSUMERS) ? MAX_CONSUMERS : n;
    if (n_act == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 63));
    return IDX_W'($urandom_range(0, n_act - 1));
  endfunction

  initial begin
    int unsigned choices [11];
    int unsigned n_rand;
    int unsigned cfg;
    int unsigned wr_pct;
    bit          quiet;
    choices = '{0, 1, 2, 3, 5, 8, 33, 63, 64, 65, 127};
    n_rand = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one consumer after reset: empty, inactive indexes, byte extremes
    send_read(0);
    send_read(1);
    send_read(63);
    send_write(8'h00);
    send_write(8'hFF);
    send_write(8'h5A);
    send_read(0);
    send_read(0);
    send_read(0);
    send_read(0);
    // no consumers: writes always go in, reads are all inactive
    write_consumers(0);
    send_write(8'hA5);
    send_read(0);
    // oversized count acts as the full set
    write_consumers(127);
    send_read(63);
    send_read(62);
    send_write(8'h80);
    send_write(8'h01);
    write_consumers(64);
    send_read(63);
    send_read(0);

    // three readers left at different lags, then each read further from its own position
    write_consumers(3);
    repeat (30) begin
      send_write(BYTE_W'($urandom));
      pause();
    end
    repeat (10) send_read(1);
    repeat (20) send_read(2);
    drain();
    repeat ($urandom_range(8, 16)) begin
      send_read(0);
      pause();
    end
    repeat ($urandom_range(8, 16)) send_read(1);
    repeat ($urandom_range(8, 16)) begin
      send_read(2);
      pause();
    end

    while (n_rand < 420) begin
      cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : choices[$urandom_range(0, 10)];
      write_consumers(cfg);
      quiet = ($urandom_range(0, 3) == 0);
      wr_pct = $urandom_range(25, 75);
      repeat ($urandom_range(40, 90)) begin
        if ($urandom_range(0, 99) < wr_pct) send_write(BYTE_W'($urandom));
        else send_read(pick_reader(cfg));
        n_rand++;
        if (!quiet) pause();
        if ($urandom_range(0, 79) == 0) drain();
      end
    end
    drain();

    $display("covered %0d requests: %0d writes stored, %0d rejected full, %0d reads returned",
             sb.n_req, sb.n_wr_taken, sb.n_full, sb.n_rd_taken);
    $display("  %0d reads empty, %0d reads by inactive consumers, %0d count register writes",
             sb.n_empty, sb.n_badidx, n_cfg);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== multi_reader_ring_buffer.f =====
design/mrrb_pkg.sv
design/mrrb_store.sv
design/mrrb_ctrl.sv
design/multi_reader_ring_buffer.sv
dv/tb.sv
